@@ rtl/ode_pkg.sv @@
// ============================================================================
// ode_pkg: shared types, constants and microcode for the ODE step unit
// Word format, shared ALU request/response types and the step program.
// ============================================================================
package ode_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 24;
    localparam int PROD_BITS = 2 * WORD_BITS;
    localparam int Q_BITS    = PROD_BITS - FRAC_BITS;

    // Division by three as a multiply by a reciprocal, valid for 32-bit words.
    localparam logic [WORD_BITS-1:0] DIV3_RECIP = 32'hAAAA_AAAB;
    localparam int                   DIV3_SHIFT = 33;

    localparam logic [WORD_BITS-1:0] WMIN_BITS = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam logic [WORD_BITS-1:0] WMAX_BITS = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic [WORD_BITS-1:0] ONE_BITS  = WORD_BITS'(1) << FRAC_BITS;

    // Configuration register indexes.
    localparam int CFG_IDX_BITS = 3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SYSTEM = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_METHOD = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DT     = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COEF_A = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COEF_B = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COEF_C = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COEF_D = 3'd6;

    localparam int DT_BITS = 31;
    localparam logic [DT_BITS-1:0]   DT_RESET     = 31'd838861;
    localparam logic [WORD_BITS-1:0] COEF_A_RESET = 32'd33554432;
    localparam logic [WORD_BITS-1:0] COEF_B_RESET = 32'd50331648;
    localparam logic [WORD_BITS-1:0] COEF_C_RESET = 32'd67108864;
    localparam logic [WORD_BITS-1:0] COEF_D_RESET = 32'd83886080;

    typedef enum logic [2:0] {
        OP_MOV, OP_ADD, OP_NEG, OP_MUL, OP_DIV6, OP_END
    } t_op;

    typedef enum logic [1:0] {
        C_ALL, C_LV, C_HO, C_EU
    } t_cond;

    typedef enum logic [3:0] {
        R_X, R_Y, R_VX, R_VY, R_KX, R_KY, R_SX, R_SY, R_T, R_U,
        R_A, R_B, R_C, R_D, R_DT, R_HDT
    } t_reg;

    typedef enum logic [0:0] {
        ST_IDLE, ST_RUN
    } t_state;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_reg  dst;
        t_reg  sa;
        t_reg  sb;
    } t_instr;

    typedef struct packed {
        t_op                   op;
        logic                  capture;
        logic [WORD_BITS-1:0]  a;
        logic [WORD_BITS-1:0]  b;
    } t_alu_req;

    typedef struct packed {
        logic [WORD_BITS-1:0] res;
        logic                 sat;
    } t_alu_rsp;

    // Program layout: start addresses of each block.
    localparam int PC_BITS = 7;
    localparam logic [PC_BITS-1:0] PC_D1   = 7'd2;
    localparam logic [PC_BITS-1:0] PC_EU   = 7'd12;
    localparam logic [PC_BITS-1:0] PC_SEED = 7'd17;
    localparam logic [PC_BITS-1:0] PC_AD2  = 7'd19;
    localparam logic [PC_BITS-1:0] PC_D2   = 7'd23;
    localparam logic [PC_BITS-1:0] PC_AC2  = 7'd33;
    localparam logic [PC_BITS-1:0] PC_AD3  = 7'd37;
    localparam logic [PC_BITS-1:0] PC_D3   = 7'd41;
    localparam logic [PC_BITS-1:0] PC_AC3  = 7'd51;
    localparam logic [PC_BITS-1:0] PC_AD4  = 7'd55;
    localparam logic [PC_BITS-1:0] PC_D4   = 7'd59;
    localparam logic [PC_BITS-1:0] PC_FIN  = 7'd69;
    localparam logic [PC_BITS-1:0] PC_LAST = 7'd77;

    function automatic t_instr mk(t_op op, t_cond cond, t_reg dst, t_reg sa, t_reg sb);
        t_instr r;
        r.op   = op;
        r.cond = cond;
        r.dst  = dst;
        r.sa   = sa;
        r.sb   = sb;
        return r;
    endfunction

    // Derivative at (VX, VY) into (KX, KY); the temporaries T and U are scratch.
    function automatic t_instr deriv_instr(logic [3:0] j);
        t_instr r;
        case (j)
            4'd0:    r = mk(OP_MUL, C_LV, R_T,  R_B,  R_VY);
            4'd1:    r = mk(OP_NEG, C_LV, R_T,  R_T,  R_T);
            4'd2:    r = mk(OP_ADD, C_LV, R_T,  R_A,  R_T);
            4'd3:    r = mk(OP_MUL, C_LV, R_KX, R_VX, R_T);
            4'd4:    r = mk(OP_MUL, C_LV, R_U,  R_C,  R_VX);
            4'd5:    r = mk(OP_NEG, C_LV, R_T,  R_D,  R_D);
            4'd6:    r = mk(OP_ADD, C_LV, R_U,  R_U,  R_T);
            4'd7:    r = mk(OP_MUL, C_LV, R_KY, R_VY, R_U);
            4'd8:    r = mk(OP_NEG, C_HO, R_KX, R_VY, R_VY);
            4'd9:    r = mk(OP_MOV, C_HO, R_KY, R_VX, R_VX);
            default: r = mk(OP_END, C_ALL, R_T, R_T, R_T);
        endcase
        return r;
    endfunction

    // Stage point (VX, VY) = state + K * h.
    function automatic t_instr adv_instr(logic [1:0] j, t_reg h);
        t_instr r;
        case (j)
            2'd0:    r = mk(OP_MUL, C_ALL, R_T,  R_KX, h);
            2'd1:    r = mk(OP_ADD, C_ALL, R_VX, R_X,  R_T);
            2'd2:    r = mk(OP_MUL, C_ALL, R_U,  R_KY, h);
            default: r = mk(OP_ADD, C_ALL, R_VY, R_Y,  R_U);
        endcase
        return r;
    endfunction

    // Weighted sum: S += 2K, with the doubling saturated first.
    function automatic t_instr acc_instr(logic [1:0] j);
        t_instr r;
        case (j)
            2'd0:    r = mk(OP_ADD, C_ALL, R_T,  R_KX, R_KX);
            2'd1:    r = mk(OP_ADD, C_ALL, R_SX, R_SX, R_T);
            2'd2:    r = mk(OP_ADD, C_ALL, R_T,  R_KY, R_KY);
            default: r = mk(OP_ADD, C_ALL, R_SY, R_SY, R_T);
        endcase
        return r;
    endfunction

    function automatic t_instr euler_instr(logic [2:0] j);
        t_instr r;
        case (j)
            3'd0:    r = mk(OP_MUL, C_EU, R_T, R_KX, R_DT);
            3'd1:    r = mk(OP_ADD, C_EU, R_X, R_X,  R_T);
            3'd2:    r = mk(OP_MUL, C_EU, R_U, R_KY, R_DT);
            3'd3:    r = mk(OP_ADD, C_EU, R_Y, R_Y,  R_U);
            default: r = mk(OP_END, C_EU, R_T, R_T,  R_T);
        endcase
        return r;
    endfunction

    function automatic t_instr fin_instr(logic [3:0] j);
        t_instr r;
        case (j)
            4'd0:    r = mk(OP_ADD,  C_ALL, R_SX, R_SX, R_KX);
            4'd1:    r = mk(OP_ADD,  C_ALL, R_SY, R_SY, R_KY);
            4'd2:    r = mk(OP_MUL,  C_ALL, R_T,  R_SX, R_DT);
            4'd3:    r = mk(OP_DIV6, C_ALL, R_T,  R_T,  R_T);
            4'd4:    r = mk(OP_ADD,  C_ALL, R_X,  R_X,  R_T);
            4'd5:    r = mk(OP_MUL,  C_ALL, R_U,  R_SY, R_DT);
            4'd6:    r = mk(OP_DIV6, C_ALL, R_U,  R_U,  R_U);
            4'd7:    r = mk(OP_ADD,  C_ALL, R_Y,  R_Y,  R_U);
            default: r = mk(OP_END,  C_ALL, R_T,  R_T,  R_T);
        endcase
        return r;
    endfunction

    function automatic t_instr fetch(logic [PC_BITS-1:0] pc);
        t_instr               r;
        logic [PC_BITS-1:0]   d;
        d = '0;
        if (pc < PC_D1) begin
            r = pc[0] ? mk(OP_MOV, C_ALL, R_VY, R_Y, R_Y) : mk(OP_MOV, C_ALL, R_VX, R_X, R_X);
        end else if (pc < PC_EU) begin
            d = pc - PC_D1;
            r = deriv_instr(d[3:0]);
        end else if (pc < PC_SEED) begin
            d = pc - PC_EU;
            r = euler_instr(d[2:0]);
        end else if (pc < PC_AD2) begin
            d = pc - PC_SEED;
            r = d[0] ? mk(OP_MOV, C_ALL, R_SY, R_KY, R_KY)
                     : mk(OP_MOV, C_ALL, R_SX, R_KX, R_KX);
        end else if (pc < PC_D2) begin
            d = pc - PC_AD2;
            r = adv_instr(d[1:0], R_HDT);
        end else if (pc < PC_AC2) begin
            d = pc - PC_D2;
            r = deriv_instr(d[3:0]);
        end else if (pc < PC_AD3) begin
            d = pc - PC_AC2;
            r = acc_instr(d[1:0]);
        end else if (pc < PC_D3) begin
            d = pc - PC_AD3;
            r = adv_instr(d[1:0], R_HDT);
        end else if (pc < PC_AC3) begin
            d = pc - PC_D3;
            r = deriv_instr(d[3:0]);
        end else if (pc < PC_AD4) begin
            d = pc - PC_AC3;
            r = acc_instr(d[1:0]);
        end else if (pc < PC_D4) begin
            d = pc - PC_AD4;
            r = adv_instr(d[1:0], R_DT);
        end else if (pc < PC_FIN) begin
            d = pc - PC_D4;
            r = deriv_instr(d[3:0]);
        end else if (pc <= PC_LAST) begin
            d = pc - PC_FIN;
            r = fin_instr(d[3:0]);
        end else begin
            r = mk(OP_END, C_ALL, R_T, R_T, R_T);
        end
        return r;
    endfunction

endpackage

@@ rtl/ode_alu.sv @@
// ============================================================================
// ode_alu: shared saturating arithmetic unit
// One unsigned 32x32 multiplier with a product register, plus add, negate
// and move. Multiply and divide-by-six go through the product register.
// ============================================================================
module ode_alu (
    input  logic              i_clk,
    input  ode_pkg::t_alu_req i_req,
    output ode_pkg::t_alu_rsp o_rsp
);
    import ode_pkg::*;

    localparam logic [PROD_BITS-1:0] ROUND_HALF = PROD_BITS'(1) << (FRAC_BITS - 1);
    localparam logic [Q_BITS-1:0]    Q_HALF     = Q_BITS'(1) << (WORD_BITS - 1);
    localparam logic [Q_BITS-1:0]    Q_WMAX     = Q_HALF - Q_BITS'(1);

    logic [WORD_BITS-1:0] ua, ub, mag_a, mag_b, mul_a, mul_b;
    logic [WORD_BITS:0]   div_n;
    logic                 mul_neg;
    logic [PROD_BITS-1:0] r_prod, rnd;
    logic                 r_neg;
    logic [Q_BITS-1:0]    q;
    logic [WORD_BITS-1:0] q_lo, q6, res;
    logic [WORD_BITS:0]   sum;
    logic                 sat;

    always_comb begin
        ua    = i_req.a;
        ub    = i_req.b;
        mag_a = ua[WORD_BITS-1] ? (~ua + 1'b1) : ua;
        mag_b = ub[WORD_BITS-1] ? (~ub + 1'b1) : ub;
        // Rounded division by six: floor((|a| + 3) / 2) / 3.
        div_n = {1'b0, mag_a} + (WORD_BITS+1)'(3);
        if (i_req.op == OP_DIV6) begin
            mul_a   = div_n[WORD_BITS:1];
            mul_b   = DIV3_RECIP;
            mul_neg = ua[WORD_BITS-1];
        end else begin
            mul_a   = mag_a;
            mul_b   = mag_b;
            mul_neg = ua[WORD_BITS-1] ^ ub[WORD_BITS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.capture) begin
            r_prod <= PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
            r_neg  <= mul_neg;
        end
    end

    always_comb begin
        rnd  = r_prod + ROUND_HALF;
        q    = rnd[PROD_BITS-1:FRAC_BITS];
        q_lo = q[WORD_BITS-1:0];
        q6   = WORD_BITS'(r_prod >> DIV3_SHIFT);
        sum  = {ua[WORD_BITS-1], ua} + {ub[WORD_BITS-1], ub};
        res  = ua;
        sat  = 1'b0;
        case (i_req.op)
            OP_MOV: begin
                res = ua;
            end
            OP_NEG: begin
                if (ua == WMIN_BITS) begin
                    res = WMAX_BITS;
                    sat = 1'b1;
                end else begin
                    res = ~ua + 1'b1;
                end
            end
            OP_ADD: begin
                if (sum[WORD_BITS] != sum[WORD_BITS-1]) begin
                    res = sum[WORD_BITS] ? WMIN_BITS : WMAX_BITS;
                    sat = 1'b1;
                end else begin
                    res = sum[WORD_BITS-1:0];
                end
            end
            OP_MUL: begin
                // A negative magnitude of exactly half the range lands on the
                // most negative word without saturating.
                if (r_neg) begin
                    if (q > Q_HALF) begin
                        res = WMIN_BITS;
                        sat = 1'b1;
                    end else begin
                        res = ~q_lo + 1'b1;
                    end
                end else if (q > Q_WMAX) begin
                    res = WMAX_BITS;
                    sat = 1'b1;
                end else begin
                    res = q_lo;
                end
            end
            OP_DIV6: begin
                res = r_neg ? (~q6 + 1'b1) : q6;
            end
            default: begin
                res = ua;
            end
        endcase
        o_rsp.res = res;
        o_rsp.sat = sat;
    end

endmodule

@@ rtl/ode_rk4_euler_step_unit.sv @@
// ============================================================================
// ode_rk4_euler_step_unit: two-variable ODE integrator, RK4 or Euler step
// A load item reaches the output register at its accept edge.
// A step item runs its micro-instructions in order through the shared ALU,
// each multiply with a product phase and a write-back phase, and ends by
// waiting for a free output register. One item at a time.
// Reset (synchronous, active low) restores the registers to their defaults
// and the state to (1.0, 1.0).
// ============================================================================
module ode_rk4_euler_step_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // [31:0] init_x, [63:32] init_y
    input  logic [0:0]  i_s_tuser,   // [0] func
    // Result stream.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,   // [31:0] out_x, [63:32] out_y
    output logic [0:0]  o_m_tuser,   // [0] overflow
    // Configuration writes.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import ode_pkg::*;

    // Configuration registers.
    logic                 r_sys, r_method;
    logic [DT_BITS-1:0]   r_dt;
    logic [WORD_BITS-1:0] r_coef_a, r_coef_b, r_coef_c, r_coef_d;

    // Integrator state and the scratch registers of the step program.
    logic [WORD_BITS-1:0] r_x, r_y;
    logic [WORD_BITS-1:0] r_vx, r_vy, r_kx, r_ky, r_sx, r_sy, r_t, r_u;

    // Sequencer.
    t_state             r_state, n_state;
    logic [PC_BITS-1:0] r_pc, n_pc;
    logic               r_phase, n_phase;
    logic               r_sat;
    t_instr             ins;
    logic               active, wb_en, done, s_ready, s_fire, load_fire, out_free;

    // Output register.
    logic                 r_out_valid, r_out_ovf;
    logic [WORD_BITS-1:0] r_out_x, r_out_y;

    t_alu_req alu_req;
    t_alu_rsp alu_rsp;

    assign ins       = fetch(r_pc);
    assign out_free  = !r_out_valid || i_m_tready;
    assign s_fire    = i_s_tvalid && s_ready;
    assign load_fire = s_fire && !i_s_tuser[0];

    // The condition field lets one program serve both systems and methods.
    always_comb begin
        case (ins.cond)
            C_ALL:   active = 1'b1;
            C_LV:    active = !r_sys;
            C_HO:    active = r_sys;
            C_EU:    active = r_method;
            default: active = 1'b1;
        endcase
    end

    // Operand selection for the shared ALU.
    always_comb begin
        alu_req.op      = ins.op;
        alu_req.capture = (r_state == ST_RUN) && !r_phase;
        case (ins.sa)
            R_X:     alu_req.a = r_x;
            R_Y:     alu_req.a = r_y;
            R_VX:    alu_req.a = r_vx;
            R_VY:    alu_req.a = r_vy;
            R_KX:    alu_req.a = r_kx;
            R_KY:    alu_req.a = r_ky;
            R_SX:    alu_req.a = r_sx;
            R_SY:    alu_req.a = r_sy;
            R_T:     alu_req.a = r_t;
            R_U:     alu_req.a = r_u;
            R_A:     alu_req.a = r_coef_a;
            R_B:     alu_req.a = r_coef_b;
            R_C:     alu_req.a = r_coef_c;
            R_D:     alu_req.a = r_coef_d;
            R_DT:    alu_req.a = {1'b0, r_dt};
            R_HDT:   alu_req.a = {2'b00, r_dt[DT_BITS-1:1]};
            default: alu_req.a = r_t;
        endcase
        case (ins.sb)
            R_X:     alu_req.b = r_x;
            R_Y:     alu_req.b = r_y;
            R_VX:    alu_req.b = r_vx;
            R_VY:    alu_req.b = r_vy;
            R_KX:    alu_req.b = r_kx;
            R_KY:    alu_req.b = r_ky;
            R_SX:    alu_req.b = r_sx;
            R_SY:    alu_req.b = r_sy;
            R_T:     alu_req.b = r_t;
            R_U:     alu_req.b = r_u;
            R_A:     alu_req.b = r_coef_a;
            R_B:     alu_req.b = r_coef_b;
            R_C:     alu_req.b = r_coef_c;
            R_D:     alu_req.b = r_coef_d;
            R_DT:    alu_req.b = {1'b0, r_dt};
            R_HDT:   alu_req.b = {2'b00, r_dt[DT_BITS-1:1]};
            default: alu_req.b = r_t;
        endcase
    end

    ode_alu u_alu (
        .i_clk (i_clk),
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    // Next state. Instructions whose condition is false are skipped. A
    // multiply captures its product in the first phase and writes back in
    // the second. The final instruction waits until the output register
    // is free, so a result is never overwritten before it is taken.
    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        n_phase = r_phase;
        wb_en   = 1'b0;
        done    = 1'b0;
        s_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                s_ready = out_free;
                if (i_s_tvalid && out_free && i_s_tuser[0]) begin
                    n_state = ST_RUN;
                    n_pc    = '0;
                    n_phase = 1'b0;
                end
            end
            ST_RUN: begin
                if (!active) begin
                    n_pc = r_pc + 1'b1;
                end else begin
                    case (ins.op)
                        OP_END: begin
                            if (out_free) begin
                                done    = 1'b1;
                                n_state = ST_IDLE;
                            end
                        end
                        OP_MUL, OP_DIV6: begin
                            if (!r_phase) begin
                                n_phase = 1'b1;
                            end else begin
                                wb_en   = 1'b1;
                                n_phase = 1'b0;
                                n_pc    = r_pc + 1'b1;
                            end
                        end
                        default: begin
                            wb_en = 1'b1;
                            n_pc  = r_pc + 1'b1;
                        end
                    endcase
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_s_tready  = s_ready;
    assign o_cfg_ready = 1'b1;

    // Control, configuration and integrator state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pc        <= '0;
            r_phase     <= 1'b0;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
            r_sys       <= 1'b0;
            r_method    <= 1'b0;
            r_dt        <= DT_RESET;
            r_coef_a    <= COEF_A_RESET;
            r_coef_b    <= COEF_B_RESET;
            r_coef_c    <= COEF_C_RESET;
            r_coef_d    <= COEF_D_RESET;
            r_x         <= ONE_BITS;
            r_y         <= ONE_BITS;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_phase <= n_phase;

            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_SYSTEM: r_sys    <= i_cfg_data[0];
                    CFG_METHOD: r_method <= i_cfg_data[0];
                    CFG_DT:     r_dt     <= i_cfg_data[DT_BITS-1:0];
                    CFG_COEF_A: r_coef_a <= i_cfg_data;
                    CFG_COEF_B: r_coef_b <= i_cfg_data;
                    CFG_COEF_C: r_coef_c <= i_cfg_data;
                    CFG_COEF_D: r_coef_d <= i_cfg_data;
                    default: ;
                endcase
            end

            if (s_fire) begin
                r_sat <= 1'b0;
            end else if (wb_en) begin
                r_sat <= r_sat | alu_rsp.sat;
            end

            // 32-bit words never saturate on load.
            if (load_fire) begin
                r_x <= i_s_tdata[WORD_BITS-1:0];
                r_y <= i_s_tdata[2*WORD_BITS-1:WORD_BITS];
            end else if (wb_en && ins.dst == R_X) begin
                r_x <= alu_rsp.res;
            end else if (wb_en && ins.dst == R_Y) begin
                r_y <= alu_rsp.res;
            end

            if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (load_fire || done) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    // Scratch registers and output payload; no reset needed.
    always_ff @(posedge i_clk) begin
        if (wb_en) begin
            case (ins.dst)
                R_VX:    r_vx <= alu_rsp.res;
                R_VY:    r_vy <= alu_rsp.res;
                R_KX:    r_kx <= alu_rsp.res;
                R_KY:    r_ky <= alu_rsp.res;
                R_SX:    r_sx <= alu_rsp.res;
                R_SY:    r_sy <= alu_rsp.res;
                R_T:     r_t  <= alu_rsp.res;
                R_U:     r_u  <= alu_rsp.res;
                default: ;
            endcase
        end
        if (load_fire) begin
            r_out_x   <= i_s_tdata[WORD_BITS-1:0];
            r_out_y   <= i_s_tdata[2*WORD_BITS-1:WORD_BITS];
            r_out_ovf <= 1'b0;
        end else if (done) begin
            r_out_x   <= r_x;
            r_out_y   <= r_y;
            r_out_ovf <= r_sat;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_y, r_out_x};
    assign o_m_tuser  = r_out_ovf;

    // No item is taken while a step program is running.
    a_no_accept_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> !o_s_tready)
        else $error("input accepted during a step");

    // Finishing a step always presents a result in the next cycle.
    a_done_shows_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |=> o_m_tvalid)
        else $error("finished step left no result");

    // The second multiply phase only exists for multiply-type instructions.
    a_phase_mul_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> (r_state == ST_RUN && (ins.op == OP_MUL || ins.op == OP_DIV6)))
        else $error("multiply phase on a non-multiply instruction");

    // The program counter never runs past the final instruction.
    a_pc_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_pc <= PC_LAST))
        else $error("program counter out of range");

endmodule
